@@ rtl/core/first_fit_free_list_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit free-list allocator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// check gated off while reset is asserted
`define FFA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also holds through reset
`define FFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFA_ASSERT(lbl, clk, rstn, prop, msg)
`define FFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the free-list allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ADDR_W     = 12;
  localparam int SIZE_W     = 13;
  localparam int HEAP_BYTES = 4 * 1024;
  localparam logic [SIZE_W-1:0] MIN_BLOCK_RESET = SIZE_W'(16);

  // action codes
  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_CLEAR   = 3'd1;
  localparam logic [2:0] ACT_ALLOC   = 3'd2;
  localparam logic [2:0] ACT_REBUILD = 3'd3;
  localparam logic [2:0] ACT_APPEND  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADSIZE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_APPEND
  } state_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] size_bytes;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] grant_address;
    logic [SIZE_W-1:0] grant_size;
    logic [SIZE_W-1:0] avail_bytes;
  } out_t;

  // one free-list entry
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] length;
  } entry_t;

endpackage

@@ rtl/core/ffa_table.sv @@
// ----------------------------------------------------------------------------
// ffa_table
// Free-list entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffa_table #(
  parameter int DEPTH = 256,
  parameter int IW    = 8
) (
  input  logic           clk,
  input  logic           we,
  input  logic [IW-1:0]  waddr,
  input  ffa_pkg::entry_t wdata,
  input  logic [IW-1:0]  raddr,
  output ffa_pkg::entry_t rdata
);

  ffa_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/first_fit_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// Address-ordered free-block table with first-fit allocation and sweep append.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------------------
//  in      | start, busy, in_data           | beat when start && !busy
//  out     | out_valid, out_data            | one-cycle strobe, no stall
//  cfg     | cfg_valid, cfg_ready, cfg_data | beat when valid && ready
//
// Init, clear, rebuild, rejected and unknown actions: result in the cycle after start.
// Allocate scans one entry per cycle from the table's single read port; when
// the whole block is removed, each later entry is moved down one row. Append
// that replaces the table or lands in an empty one answers in the cycle after
// start; append with an open tail otherwise first reads the last entry.
// Synchronous active-low reset empties the table; no clearing pass needed.
// ----------------------------------------------------------------------------
`include "first_fit_free_list_allocator_assert.svh"

module first_fit_free_list_allocator #(
  parameter int MAX_FREE_BLOCKS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ffa_pkg::in_t                in_data,
  output logic                        out_valid,
  output ffa_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffa_pkg::SIZE_W-1:0]  cfg_data
);

  localparam int IW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int SW = ffa_pkg::SIZE_W;
  localparam int AW = ffa_pkg::ADDR_W;
  localparam logic [CW-1:0]   MAXC = CW'(MAX_FREE_BLOCKS);
  localparam logic [SW:0]     HEAP = (SW+1)'(ffa_pkg::HEAP_BYTES);

  ffa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  total_r, total_nxt;
  logic           tail_r, tail_nxt;
  logic [SW-1:0]  min_r;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [SW-1:0]  size_r, size_nxt;
  logic [AW-1:0]  gaddr_r, gaddr_nxt;
  logic [SW-1:0]  gsize_r, gsize_nxt;
  logic           out_valid_r, out_valid_nxt;
  ffa_pkg::out_t  out_r, out_nxt;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  ffa_pkg::entry_t mem_wdata, mem_rdata;

  logic [SW-1:0]  eff_min;
  logic           in_ok;
  logic [CW-1:0]  idx_p1, idx_p2, count_m1;
  logic [SW-1:0]  remain;
  logic [SW:0]    clamp_sub;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ffa_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // zero minimum acts as one
  assign eff_min  = (min_r == '0) ? SW'(1) : min_r;
  assign idx_p1   = idx_r + CW'(1);
  assign idx_p2   = idx_r + CW'(2);
  assign count_m1 = count_r - CW'(1);
  assign remain   = mem_rdata.length - size_r;

  // size and extent check for init and append blocks
  assign in_ok = (in_data.size_bytes >= eff_min) &&
                 ({1'b0, in_data.size_bytes} <= HEAP) &&
                 (({2'b0, in_data.block_address} + {1'b0, in_data.size_bytes}) <=
                  {1'b0, HEAP});

  ffa_table #(.DEPTH(MAX_FREE_BLOCKS), .IW(IW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= ffa_pkg::MIN_BLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    size_r  <= size_nxt;
    gaddr_r <= gaddr_nxt;
    gsize_r <= gsize_nxt;
    out_r   <= out_nxt;
  end

  // next state, table accesses and result
  always_comb begin
    logic          emit;
    ffa_pkg::status_t st;
    logic [AW-1:0] ga;
    logic [SW-1:0] gs;
    logic [SW:0]   sum_tot;
    logic [SW:0]   tail_end;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    total_nxt = total_r;
    tail_nxt  = tail_r;
    addr_nxt  = addr_r;
    size_nxt  = size_r;
    gaddr_nxt = gaddr_r;
    gsize_nxt = gsize_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    emit      = 1'b0;
    st        = ffa_pkg::ST_OK;
    ga        = '0;
    gs        = '0;
    clamp_sub = '0;
    sum_tot   = {1'b0, total_r} + {1'b0, in_data.size_bytes};
    tail_end  = {1'b0, mem_rdata.start} + {1'b0, mem_rdata.length};

    case (state_r)
      ffa_pkg::S_IDLE: begin
        if (start) begin
          addr_nxt = in_data.block_address;
          size_nxt = in_data.size_bytes;
          case (in_data.action)
            ffa_pkg::ACT_INIT: begin
              emit = 1'b1;
              if (!in_ok) begin
                st = ffa_pkg::ST_BADSIZE;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = '{start: in_data.block_address, length: in_data.size_bytes};
                count_nxt = CW'(1);
                total_nxt = in_data.size_bytes;
                tail_nxt  = 1'b0;
              end
            end
            ffa_pkg::ACT_CLEAR, ffa_pkg::ACT_REBUILD: begin
              emit      = 1'b1;
              count_nxt = '0;
              total_nxt = '0;
              tail_nxt  = 1'b0;
            end
            ffa_pkg::ACT_ALLOC: begin
              if (in_data.size_bytes == '0) begin
                emit = 1'b1;
                st   = ffa_pkg::ST_BADSIZE;
              end else if (count_r == '0) begin
                emit = 1'b1;
                st   = ffa_pkg::ST_NOFIT;
              end else begin
                // first read of entry 0
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = ffa_pkg::S_SCAN;
              end
            end
            ffa_pkg::ACT_APPEND: begin
              if (!in_ok || sum_tot > HEAP) begin
                emit = 1'b1;
                st   = ffa_pkg::ST_BADSIZE;
              end else if (!tail_r || count_r == '0) begin
                // table replaced, or first entry of a sweep
                emit      = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = '{start: in_data.block_address, length: in_data.size_bytes};
                count_nxt = CW'(1);
                total_nxt = sum_tot[SW-1:0];
                tail_nxt  = 1'b1;
              end else begin
                mem_raddr = count_m1[IW-1:0];
                state_nxt = ffa_pkg::S_APPEND;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ffa_pkg::S_SCAN: begin
        if (mem_rdata.length >= size_r) begin
          if (remain >= eff_min) begin
            // split: keep the upper part in place
            mem_we    = 1'b1;
            mem_waddr = idx_r[IW-1:0];
            mem_wdata = '{start: mem_rdata.start + AW'(size_r), length: remain};
            ga        = mem_rdata.start;
            gs        = size_r;
            clamp_sub = {1'b0, total_r} - {1'b0, size_r};
            total_nxt = clamp_sub[SW] ? '0 : clamp_sub[SW-1:0];
            emit      = 1'b1;
            state_nxt = ffa_pkg::S_IDLE;
          end else if (idx_p1 < count_r) begin
            // hand out whole block, move later entries down
            gaddr_nxt = mem_rdata.start;
            gsize_nxt = mem_rdata.length;
            mem_raddr = idx_p1[IW-1:0];
            state_nxt = ffa_pkg::S_SHIFT;
          end else begin
            ga        = mem_rdata.start;
            gs        = mem_rdata.length;
            clamp_sub = {1'b0, total_r} - {1'b0, mem_rdata.length};
            total_nxt = clamp_sub[SW] ? '0 : clamp_sub[SW-1:0];
            count_nxt = count_m1;
            emit      = 1'b1;
            state_nxt = ffa_pkg::S_IDLE;
          end
        end else if (idx_p1 < count_r) begin
          mem_raddr = idx_p1[IW-1:0];
          idx_nxt   = idx_p1;
        end else begin
          st        = ffa_pkg::ST_NOFIT;
          emit      = 1'b1;
          state_nxt = ffa_pkg::S_IDLE;
        end
      end

      ffa_pkg::S_SHIFT: begin
        // read data is entry idx+1, written to idx
        mem_we    = 1'b1;
        mem_waddr = idx_r[IW-1:0];
        mem_wdata = mem_rdata;
        if (idx_p2 < count_r) begin
          mem_raddr = idx_p2[IW-1:0];
          idx_nxt   = idx_p1;
        end else begin
          ga        = gaddr_r;
          gs        = gsize_r;
          clamp_sub = {1'b0, total_r} - {1'b0, gsize_r};
          total_nxt = clamp_sub[SW] ? '0 : clamp_sub[SW-1:0];
          count_nxt = count_m1;
          emit      = 1'b1;
          state_nxt = ffa_pkg::S_IDLE;
        end
      end

      ffa_pkg::S_APPEND: begin
        sum_tot = {1'b0, total_r} + {1'b0, size_r};
        if (tail_end == {1'b0, AW'(0), 1'b0} + {2'b0, addr_r}) begin
          // adjacent to the last entry: grow it
          mem_we    = 1'b1;
          mem_waddr = count_m1[IW-1:0];
          mem_wdata = '{start: mem_rdata.start, length: mem_rdata.length + size_r};
          total_nxt = sum_tot[SW-1:0];
          tail_nxt  = 1'b1;
        end else if (count_r >= MAXC) begin
          st = ffa_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = count_r[IW-1:0];
          mem_wdata = '{start: addr_r, length: size_r};
          count_nxt = count_r + CW'(1);
          total_nxt = sum_tot[SW-1:0];
          tail_nxt  = 1'b1;
        end
        emit      = 1'b1;
        state_nxt = ffa_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ffa_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt         = emit;
    out_nxt.status        = st;
    out_nxt.grant_address = ga;
    out_nxt.grant_size    = gs;
    out_nxt.avail_bytes   = total_nxt;
  end

  // a result follows only an accepted beat or work in progress
  `FFA_ASSERT(a_out_cause, clk, rst_n, out_valid |-> $past(busy || start), "result without request")
  // table never holds more entries than it has rows
  `FFA_ASSERT(a_count_max, clk, rst_n, count_r <= MAXC, "entry count overflow")
  // free total stays within the heap
  `FFA_ASSERT(a_total_max, clk, rst_n, {1'b0, total_r} <= HEAP, "free total above heap size")
  // no table write when idle without a start
  `FFA_ASSERT_ALWAYS(a_we_cause, clk, mem_we |-> (busy || start), "stray table write")

endmodule
